// ===== rtl/cvp_pkg.sv =====
// ----------------------------------------------------------------------------
// cvp_pkg
// Shared types, register indexes and fixed-point helpers for the camera view
// projection pipeline.
// ----------------------------------------------------------------------------
package cvp_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_CAM_Z = 3'd2;
  localparam logic [2:0] REG_ROT_W = 3'd3;
  localparam logic [2:0] REG_ROT_I = 3'd4;
  localparam logic [2:0] REG_ROT_J = 3'd5;
  localparam logic [2:0] REG_ROT_K = 3'd6;
  localparam logic [2:0] REG_FOCAL = 3'd7;

  // Quotient bits resolved by the divider, one per stage
  localparam int DIV_BITS = 32;
  // Six transform stages, divider entry, divider steps, output register
  localparam int LATENCY  = 8 + DIV_BITS;

  localparam logic signed [31:0] Q_ONE   = 32'sd1073741824;
  localparam logic signed [36:0] LIM33   = 37'sd8589934591;
  localparam logic [31:0]        SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0]        SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] rot_w;
    logic signed [31:0] rot_i;
    logic signed [31:0] rot_j;
    logic signed [31:0] rot_k;
    logic [30:0]        focal;
  } cvp_cfg_t;

  // One projection job for a divider lane
  typedef struct packed {
    logic        valid;
    logic        neg;    // sign of v*z
    logic        vpos;   // v > 0
    logic        vneg;   // v < 0
    logic        zz;     // rotated z is zero
    logic        side;   // ahead flag, carried along
    logic [63:0] num;    // |v| * f
    logic [32:0] den;    // |z|
  } cvp_div_in_t;

  typedef struct packed {
    logic        valid;
    logic        ovf;
    logic        side;
    logic [31:0] res;
  } cvp_div_out_t;

  // Q2.30 by Q16.16 product
  function automatic logic signed [65:0] mul_q(input logic signed [33:0] a,
                                               input logic signed [31:0] b);
    return 66'(a) * 66'(b);
  endfunction

  // Round a product to Q16.16: floor((p + 2^29) / 2^30)
  function automatic logic signed [34:0] rnd_q(input logic signed [65:0] p);
    logic signed [66:0] s;
    s = 67'(p) + 67'sd536870912;
    return s[64:30];
  endfunction

  // Clamp to [-(2^33-1), 2^33-1]
  function automatic logic signed [33:0] clamp_r(input logic signed [36:0] v);
    logic signed [33:0] r;
    if (v > LIM33) begin
      r = LIM33[33:0];
    end else if (v < -LIM33) begin
      r = 34'(-LIM33);
    end else begin
      r = v[33:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cvp_cfg.sv =====
// ----------------------------------------------------------------------------
// cvp_cfg
// Configuration register file; quaternion parts are clamped on write.
// ----------------------------------------------------------------------------
module cvp_cfg
  import cvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cvp_cfg_t    cfg
);

  cvp_cfg_t cfg_r;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < -Q_ONE) begin
      r = -Q_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Take one write beat per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x <= '0;
      cfg_r.cam_y <= '0;
      cfg_r.cam_z <= '0;
      cfg_r.rot_w <= Q_ONE;
      cfg_r.rot_i <= '0;
      cfg_r.rot_j <= '0;
      cfg_r.rot_k <= '0;
      cfg_r.focal <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM_X: cfg_r.cam_x <= cfg_data;
        REG_CAM_Y: cfg_r.cam_y <= cfg_data;
        REG_CAM_Z: cfg_r.cam_z <= cfg_data;
        REG_ROT_W: cfg_r.rot_w <= clamp_q(cfg_data);
        REG_ROT_I: cfg_r.rot_i <= clamp_q(cfg_data);
        REG_ROT_J: cfg_r.rot_j <= clamp_q(cfg_data);
        REG_ROT_K: cfg_r.rot_k <= clamp_q(cfg_data);
        REG_FOCAL: cfg_r.focal <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cvp_xform.sv =====
// ----------------------------------------------------------------------------
// cvp_xform
// Six-stage transform: offset, two quaternion products (multiply, then
// round and sum), and the numerators of the projection quotients.
// ----------------------------------------------------------------------------
module cvp_xform
  import cvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  cvp_cfg_t           cfg,
  output cvp_div_in_t        div_x,
  output cvp_div_in_t        div_y
);

  logic [5:1] vld_r;

  logic signed [33:0] tx_r, ty_r, tz_r;
  logic signed [65:0] m1_r [12];
  logic signed [33:0] ra_r, rb_r, rc_r, rd_r;
  logic signed [65:0] m2_r [12];
  logic signed [33:0] sx_r, sy_r, sz_r;
  cvp_div_in_t        dx_r, dy_r;

  logic [32:0] ax, ay, az;
  logic        zneg;

  // Advance valid bits; nothing ever stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:1], in_valid};
    end
  end

  // Stage 1: offset from camera, 33 significant bits
  always_ff @(posedge clk) begin
    tx_r <= 34'(point_x) - 34'(cfg.cam_x);
    ty_r <= 34'(point_y) - 34'(cfg.cam_y);
    tz_r <= 34'(point_z) - 34'(cfg.cam_z);
  end

  // Stage 2: products of conj(q) * (0, t)
  always_ff @(posedge clk) begin
    m1_r[0]  <= mul_q(tx_r, cfg.rot_i);
    m1_r[1]  <= mul_q(ty_r, cfg.rot_j);
    m1_r[2]  <= mul_q(tz_r, cfg.rot_k);
    m1_r[3]  <= mul_q(tx_r, cfg.rot_w);
    m1_r[4]  <= mul_q(tz_r, cfg.rot_j);
    m1_r[5]  <= mul_q(ty_r, cfg.rot_k);
    m1_r[6]  <= mul_q(ty_r, cfg.rot_w);
    m1_r[7]  <= mul_q(tz_r, cfg.rot_i);
    m1_r[8]  <= mul_q(tx_r, cfg.rot_k);
    m1_r[9]  <= mul_q(tz_r, cfg.rot_w);
    m1_r[10] <= mul_q(ty_r, cfg.rot_i);
    m1_r[11] <= mul_q(tx_r, cfg.rot_j);
  end

  // Stage 3: round, sum and clamp r
  always_ff @(posedge clk) begin
    ra_r <= clamp_r(37'(rnd_q(m1_r[0])) + 37'(rnd_q(m1_r[1])) + 37'(rnd_q(m1_r[2])));
    rb_r <= clamp_r(37'(rnd_q(m1_r[3])) - 37'(rnd_q(m1_r[4])) + 37'(rnd_q(m1_r[5])));
    rc_r <= clamp_r(37'(rnd_q(m1_r[6])) + 37'(rnd_q(m1_r[7])) - 37'(rnd_q(m1_r[8])));
    rd_r <= clamp_r(37'(rnd_q(m1_r[9])) - 37'(rnd_q(m1_r[10])) + 37'(rnd_q(m1_r[11])));
  end

  // Stage 4: products of r * q, vector part
  always_ff @(posedge clk) begin
    m2_r[0]  <= mul_q(ra_r, cfg.rot_i);
    m2_r[1]  <= mul_q(rb_r, cfg.rot_w);
    m2_r[2]  <= mul_q(rc_r, cfg.rot_k);
    m2_r[3]  <= mul_q(rd_r, cfg.rot_j);
    m2_r[4]  <= mul_q(ra_r, cfg.rot_j);
    m2_r[5]  <= mul_q(rb_r, cfg.rot_k);
    m2_r[6]  <= mul_q(rc_r, cfg.rot_w);
    m2_r[7]  <= mul_q(rd_r, cfg.rot_i);
    m2_r[8]  <= mul_q(ra_r, cfg.rot_k);
    m2_r[9]  <= mul_q(rb_r, cfg.rot_j);
    m2_r[10] <= mul_q(rc_r, cfg.rot_i);
    m2_r[11] <= mul_q(rd_r, cfg.rot_w);
  end

  // Stage 5: round, sum and clamp the rotated point
  always_ff @(posedge clk) begin
    sx_r <= clamp_r(37'(rnd_q(m2_r[0])) + 37'(rnd_q(m2_r[1]))
                  + 37'(rnd_q(m2_r[2])) - 37'(rnd_q(m2_r[3])));
    sy_r <= clamp_r(37'(rnd_q(m2_r[4])) - 37'(rnd_q(m2_r[5]))
                  + 37'(rnd_q(m2_r[6])) + 37'(rnd_q(m2_r[7])));
    sz_r <= clamp_r(37'(rnd_q(m2_r[8])) + 37'(rnd_q(m2_r[9]))
                  - 37'(rnd_q(m2_r[10])) + 37'(rnd_q(m2_r[11])));
  end

  // Magnitudes; clamped values fit 33 bits
  always_comb begin
    ax   = sx_r[33] ? 33'(-sx_r) : sx_r[32:0];
    ay   = sy_r[33] ? 33'(-sy_r) : sy_r[32:0];
    az   = sz_r[33] ? 33'(-sz_r) : sz_r[32:0];
    zneg = sz_r[33];
  end

  // Stage 6: numerators |v| * f and sign bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r.valid <= 1'b0;
      dy_r.valid <= 1'b0;
    end else begin
      dx_r.valid <= vld_r[5];
      dx_r.num   <= 64'(ax) * 64'(cfg.focal);
      dx_r.den   <= az;
      dx_r.neg   <= sx_r[33] != zneg;
      dx_r.vpos  <= !sx_r[33] && (sx_r != '0);
      dx_r.vneg  <= sx_r[33];
      dx_r.zz    <= sz_r == '0;
      dx_r.side  <= zneg || (sz_r == '0);
      dy_r.valid <= vld_r[5];
      dy_r.num   <= 64'(ay) * 64'(cfg.focal);
      dy_r.den   <= az;
      dy_r.neg   <= sy_r[33] != zneg;
      dy_r.vpos  <= !sy_r[33] && (sy_r != '0);
      dy_r.vneg  <= sy_r[33];
      dy_r.zz    <= sz_r == '0;
      dy_r.side  <= zneg || (sz_r == '0);
    end
  end

  assign div_x = dx_r;
  assign div_y = dy_r;

endmodule

// ===== rtl/cvp_div.sv =====
// ----------------------------------------------------------------------------
// cvp_div
// Pipelined restoring divider lane, one quotient bit per stage, with
// saturation and the zero-depth case applied at the output register.
// ----------------------------------------------------------------------------
module cvp_div
  import cvp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cvp_div_in_t  din,
  output cvp_div_out_t dout
);

  typedef struct packed {
    logic        neg;
    logic        vpos;
    logic        vneg;
    logic        zz;
    logic        big;   // quotient would need more than 32 bits
    logic        side;
    logic [32:0] den;
  } meta_t;

  logic                vld_r  [DIV_BITS+1];
  meta_t               meta_r [DIV_BITS+1];
  logic [32:0]         rem_r  [DIV_BITS+1];
  logic [DIV_BITS-1:0] lo_r   [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_r  [DIV_BITS+1];
  cvp_div_out_t        out_r;
  logic [31:0]         res_nxt;
  logic                ovf_nxt;
  logic [DIV_BITS-1:0] q;

  // Entry: split the numerator, check for an oversized quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0].neg  <= din.neg;
    meta_r[0].vpos <= din.vpos;
    meta_r[0].vneg <= din.vneg;
    meta_r[0].zz   <= din.zz;
    meta_r[0].side <= din.side;
    meta_r[0].den  <= din.den;
    meta_r[0].big  <= {1'b0, din.num[63:32]} >= din.den;
    rem_r[0]       <= {1'b0, din.num[63:32]};
    lo_r[0]        <= din.num[31:0];
    quo_r[0]       <= '0;
  end

  // One compare-subtract step per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [33:0] sh;
    logic [33:0] diff;
    logic        ge;

    always_comb begin
      sh   = {rem_r[k], lo_r[k][DIV_BITS-1]};
      diff = sh - {1'b0, meta_r[k].den};
      ge   = sh >= {1'b0, meta_r[k].den};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      meta_r[k+1] <= meta_r[k];
      rem_r[k+1]  <= ge ? diff[32:0] : sh[32:0];
      lo_r[k+1]   <= {lo_r[k][DIV_BITS-2:0], 1'b0};
      quo_r[k+1]  <= {quo_r[k][DIV_BITS-2:0], ge};
    end
  end

  // Saturate and apply the sign
  always_comb begin
    q       = quo_r[DIV_BITS];
    res_nxt = q;
    ovf_nxt = 1'b0;
    if (meta_r[DIV_BITS].zz) begin
      ovf_nxt = 1'b1;
      if (meta_r[DIV_BITS].vpos) begin
        res_nxt = SAT_POS;
      end else if (meta_r[DIV_BITS].vneg) begin
        res_nxt = SAT_NEG;
      end else begin
        res_nxt = '0;
      end
    end else if (meta_r[DIV_BITS].neg) begin
      if (meta_r[DIV_BITS].big || (q > SAT_NEG)) begin
        res_nxt = SAT_NEG;
        ovf_nxt = 1'b1;
      end else begin
        res_nxt = -q;
      end
    end else begin
      if (meta_r[DIV_BITS].big || (q > SAT_POS)) begin
        res_nxt = SAT_POS;
        ovf_nxt = 1'b1;
      end
    end
  end

  // Register the lane result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= vld_r[DIV_BITS];
      out_r.res   <= res_nxt;
      out_r.ovf   <= ovf_nxt;
      out_r.side  <= meta_r[DIV_BITS].side;
    end
  end

  assign dout = out_r;

endmodule

// ===== rtl/camera_view_projection.sv =====
// ----------------------------------------------------------------------------
// camera_view_projection
// World point to screen: camera offset, quaternion rotation, perspective
// divide with saturation.
// ----------------------------------------------------------------------------
// Takes one point on every clock (busy is always low) and shows its result
// on out_valid at the end of the pipeline, one result per point, in order.
// The pipeline holds six transform stages (offset, two quaternion products
// each split into multiply and round/sum, and the projection multiply), the
// divider entry stage, 32 divider stages that resolve one quotient bit each,
// and the output register. Results cannot be held off; capture them on
// out_valid. Write configuration only while no point is in flight.
module camera_view_projection
  import cvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_screen_x,
  output logic [31:0] out_screen_y,
  output logic        out_ahead,
  output logic        out_overflow
);

  cvp_cfg_t     cfg;
  cvp_div_in_t  div_x, div_y;
  cvp_div_out_t res_x, res_y;

  assign busy = 1'b0;

  cvp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvp_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .cfg      (cfg),
    .div_x    (div_x),
    .div_y    (div_y)
  );

  cvp_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .din   (div_x),
    .dout  (res_x)
  );

  cvp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .din   (div_y),
    .dout  (res_y)
  );

  // Merge the two lanes
  assign out_valid    = res_x.valid;
  assign out_screen_x = res_x.res;
  assign out_screen_y = res_y.res;
  assign out_ahead    = res_x.side & res_y.side;
  assign out_overflow = res_x.ovf | res_y.ovf;

  // Every accepted point comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

  // Both divider lanes stay in step
  a_lanes : assert property (@(posedge clk) disable iff (!rst_n)
    res_x.valid == res_y.valid && (!res_x.valid || res_x.side == res_y.side))
    else $error("divider lanes out of step");

endmodule
